// File: rtl/rsd_pkg.sv
// ----------------------------------------------------------------------------
// rsd_pkg
// Shared types and constants for the running standard deviation block.
// ----------------------------------------------------------------------------
package rsd_pkg;

    localparam int SAMPLE_BITS = 16;   // Q8.8 sample
    localparam int STD_BITS    = 16;   // Q8.8 result
    localparam int MAG_BITS    = 32;   // deviation magnitude clamp

    typedef struct packed {
        logic signed [SAMPLE_BITS-1:0] sample;
        logic                          restart;
    } rsd_in_t;

    typedef struct packed {
        logic [STD_BITS-1:0] std_dev;
        logic                valid_res;
    } rsd_out_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_MEAN_GO,
        ST_MEAN_WAIT,
        ST_DEV,
        ST_SQUARE,
        ST_ACC,
        ST_VAR_GO,
        ST_VAR_WAIT,
        ST_ROOT_GO,
        ST_ROOT_WAIT,
        ST_OUT
    } rsd_state_t;

    typedef struct packed {
        logic accept;
        logic div_start;
        logic div_var;
        logic load_mean;
        logic load_mag;
        logic load_sq;
        logic load_acc;
        logic sqrt_start;
        logic load_out;
    } rsd_cmd_t;

    typedef struct packed {
        logic div_done;
        logic sqrt_done;
        logic few_samples;
        logic out_busy;
    } rsd_sts_t;

endpackage

// File: rtl/running_std_deviation.sv
// ----------------------------------------------------------------------------
// running_std_deviation
// Running sample standard deviation of a stream of signed Q8.8 words.
// ----------------------------------------------------------------------------
// Each input word carries one Q8.8 sample and a restart flag; restart clears
// the count and both sums before the sample is taken in. Every input word
// gives exactly one result word: the sample standard deviation in unsigned
// Q8.8, saturated at 0xFFFF, with valid_res low (and std_dev zero) while
// fewer than two samples have been seen. Samples are handled one at a time.
// s_ready is low from acceptance until the result is loaded into the output
// register, and a full output register holds the result back. The shared
// radix-2 divider runs twice per sample (mean, then variance), or only for
// the mean while fewer than two samples have been seen, at one bit of a
// (32+COUNT_BITS)-bit quotient per cycle, and the square root yields one
// root bit per cycle. The result sits in an output register, so the next
// sample is taken while a result waits.
// ----------------------------------------------------------------------------
module running_std_deviation #(
    parameter int COUNT_BITS = 24     // sample counter width, 8 to 32
) (
    input  logic              aclk,
    input  logic              aresetn,

    input  logic              s_valid,
    output logic              s_ready,
    input  rsd_pkg::rsd_in_t  s_data,

    output logic              m_valid,
    input  logic              m_ready,
    output rsd_pkg::rsd_out_t m_data
);

    // command and status between sequencer and datapath
    rsd_pkg::rsd_cmd_t cmd;
    rsd_pkg::rsd_sts_t sts;

    // sequencer: holds s_ready low from acceptance until the result is
    // loaded into the output register
    rsd_control u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .cmd     (cmd),
        .sts     (sts)
    );

    // datapath: count/sum/squared-deviation state, divider, root, output
    rsd_datapath #(
        .COUNT_BITS (COUNT_BITS)
    ) u_dp (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_data  (s_data),
        .cmd     (cmd),
        .sts     (sts),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

`ifndef SYNTHESIS
    // one sample in flight: an accepted word closes the input at once
    a_one_in_flight: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !s_ready)
        else $error("input taken while a sample is still in progress");

    // a result without a valid deviation reads as zero
    a_invalid_is_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_data.valid_res |-> m_data.std_dev == '0)
        else $error("std_dev not zero with valid_res low");

    // reset empties the output register
    a_reset_clears_out: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result word present after reset");
`endif

endmodule

// File: rtl/rsd_divider.sv
// ----------------------------------------------------------------------------
// rsd_divider
// Restoring unsigned divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module rsd_divider #(
    parameter int DVD_BITS = 56,
    parameter int DVS_BITS = 24
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                start,
    input  logic [DVD_BITS-1:0] dividend,
    input  logic [DVS_BITS-1:0] divisor,
    output logic [DVD_BITS-1:0] quotient,
    output logic                done
);

    localparam int CNT_W = $clog2(DVD_BITS + 1);

    logic [DVD_BITS-1:0] dvd_reg, dvd_next;
    logic [DVS_BITS-1:0] dvs_reg, dvs_next;
    logic [DVS_BITS-1:0] rem_reg, rem_next;
    logic [CNT_W-1:0]    cnt_reg, cnt_next;
    logic                busy_reg, busy_next;
    logic                done_reg, done_next;

    logic [DVS_BITS:0]   rem_t;
    logic [DVS_BITS:0]   diff;
    logic                ge;

    assign rem_t = {rem_reg, dvd_reg[DVD_BITS-1]};
    assign diff  = rem_t - {1'b0, dvs_reg};
    assign ge    = rem_t >= {1'b0, dvs_reg};

    always_comb begin
        dvd_next  = dvd_reg;
        dvs_next  = dvs_reg;
        rem_next  = rem_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (start) begin
            dvd_next  = dividend;
            dvs_next  = divisor;
            rem_next  = '0;
            cnt_next  = CNT_W'(DVD_BITS);
            busy_next = 1'b1;
        end else if (busy_reg) begin
            dvd_next = {dvd_reg[DVD_BITS-2:0], ge};
            rem_next = ge ? diff[DVS_BITS-1:0] : rem_t[DVS_BITS-1:0];
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == CNT_W'(1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg  <= '0;
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            cnt_reg  <= cnt_next;
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
        dvd_reg <= dvd_next;
        dvs_reg <= dvs_next;
        rem_reg <= rem_next;
    end

    assign quotient = dvd_reg;
    assign done     = done_reg;

endmodule

// File: rtl/rsd_sqrt.sv
// ----------------------------------------------------------------------------
// rsd_sqrt
// Digit-by-digit integer square root, one root bit per cycle (floor).
// ----------------------------------------------------------------------------
module rsd_sqrt #(
    parameter int IN_BITS = 56
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          start,
    input  logic [IN_BITS-1:0]            radicand,
    output logic [(IN_BITS+IN_BITS%2)/2-1:0] root,
    output logic                          done
);

    localparam int RAD_W  = IN_BITS + IN_BITS % 2;
    localparam int ROOT_W = RAD_W / 2;
    localparam int REM_W  = ROOT_W + 2;
    localparam int TRY_W  = ROOT_W + 4;
    localparam int CNT_W  = $clog2(ROOT_W + 1);

    logic [RAD_W-1:0]  rad_reg, rad_next;
    logic [ROOT_W-1:0] root_reg, root_next;
    logic [REM_W-1:0]  rem_reg, rem_next;
    logic [CNT_W-1:0]  cnt_reg, cnt_next;
    logic              busy_reg, busy_next;
    logic              done_reg, done_next;

    logic [TRY_W-1:0]  rem_t;
    logic [TRY_W-1:0]  trial;
    logic [TRY_W-1:0]  diff;
    logic              ge;

    assign rem_t = {rem_reg, rad_reg[RAD_W-1 -: 2]};
    assign trial = TRY_W'({root_reg, 2'b01});
    assign diff  = rem_t - trial;
    assign ge    = rem_t >= trial;

    always_comb begin
        rad_next  = rad_reg;
        root_next = root_reg;
        rem_next  = rem_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (start) begin
            rad_next  = RAD_W'(radicand);
            root_next = '0;
            rem_next  = '0;
            cnt_next  = CNT_W'(ROOT_W);
            busy_next = 1'b1;
        end else if (busy_reg) begin
            rad_next  = {rad_reg[RAD_W-3:0], 2'b00};
            root_next = {root_reg[ROOT_W-2:0], ge};
            rem_next  = ge ? diff[REM_W-1:0] : rem_t[REM_W-1:0];
            cnt_next  = cnt_reg - 1'b1;
            if (cnt_reg == CNT_W'(1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg  <= '0;
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            cnt_reg  <= cnt_next;
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
        rad_reg  <= rad_next;
        root_reg <= root_next;
        rem_reg  <= rem_next;
    end

    assign root = root_reg;
    assign done = done_reg;

endmodule

// File: rtl/rsd_datapath.sv
// ----------------------------------------------------------------------------
// rsd_datapath
// Running sums, mean/deviation/square stages, shared divider, square root
// and the result register.
// ----------------------------------------------------------------------------
module rsd_datapath #(
    parameter int COUNT_BITS = 24
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  rsd_pkg::rsd_in_t  s_data,
    input  rsd_pkg::rsd_cmd_t cmd,
    output rsd_pkg::rsd_sts_t sts,
    output logic              m_valid,
    input  logic              m_ready,
    output rsd_pkg::rsd_out_t m_data
);

    localparam int S_W    = rsd_pkg::SAMPLE_BITS;
    localparam int SUM_W  = COUNT_BITS + S_W;
    localparam int SQ_W   = 2 * S_W + COUNT_BITS;
    localparam int DEV_W  = SUM_W + 1;
    localparam int EXT_W  = (DEV_W > 33) ? DEV_W : 33;
    localparam int MAG_W  = rsd_pkg::MAG_BITS;
    localparam int SQR_W  = 2 * MAG_W;
    localparam int ACC_W  = SQR_W + 1;
    localparam int ROOT_W = (SQ_W + SQ_W % 2) / 2;
    localparam int STD_W  = rsd_pkg::STD_BITS;

    localparam logic [COUNT_BITS-1:0] CNT_MAX = {COUNT_BITS{1'b1}};
    localparam logic [SUM_W-1:0]      SUM_MAX = {1'b0, {(SUM_W-1){1'b1}}};
    localparam logic [SUM_W-1:0]      SUM_MIN = {1'b1, {(SUM_W-1){1'b0}}};
    localparam logic [SQ_W-1:0]       SQ_MAX  = {SQ_W{1'b1}};
    localparam logic [EXT_W-1:0]      MAG_LIM = EXT_W'({MAG_W{1'b1}});

    logic [COUNT_BITS-1:0]   count_reg;
    logic signed [SUM_W-1:0] sum_reg;
    logic [SQ_W-1:0]         sqsum_reg;
    logic signed [S_W-1:0]   sample_reg;
    logic signed [SUM_W-1:0] mean_reg;
    logic [MAG_W-1:0]        mag_reg;
    logic [SQR_W-1:0]        sq_reg;
    rsd_pkg::rsd_out_t       out_reg;
    logic                    m_valid_reg;

    // sample intake: restart, count and sum update
    logic [COUNT_BITS-1:0]   count_base, count_next;
    logic signed [SUM_W-1:0] sum_base;
    logic [SUM_W:0]          sum_wide;
    logic [SUM_W-1:0]        sum_next;

    always_comb begin
        count_base = s_data.restart ? '0 : count_reg;
        count_next = (count_base == CNT_MAX) ? count_base : count_base + 1'b1;
        sum_base   = s_data.restart ? '0 : sum_reg;
        sum_wide   = (SUM_W+1)'(sum_base) + (SUM_W+1)'(s_data.sample);
        if (sum_wide[SUM_W] != sum_wide[SUM_W-1]) begin
            sum_next = sum_wide[SUM_W] ? SUM_MIN : SUM_MAX;
        end else begin
            sum_next = sum_wide[SUM_W-1:0];
        end
    end

    // shared divider: |sum| / count, then sqsum / (count - 1)
    logic [SUM_W-1:0]      sum_abs;
    logic [SQ_W-1:0]       div_dividend;
    logic [COUNT_BITS-1:0] div_divisor;
    logic [SQ_W-1:0]       div_quot;
    logic                  div_done;

    assign sum_abs      = sum_reg[SUM_W-1] ? -sum_reg : sum_reg;
    assign div_dividend = cmd.div_var ? sqsum_reg : SQ_W'(sum_abs);
    assign div_divisor  = cmd.div_var ? count_reg - 1'b1 : count_reg;

    rsd_divider #(
        .DVD_BITS (SQ_W),
        .DVS_BITS (COUNT_BITS)
    ) u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (cmd.div_start),
        .dividend (div_dividend),
        .divisor  (div_divisor),
        .quotient (div_quot),
        .done     (div_done)
    );

    // mean carries the sign of the sum (truncation toward zero)
    logic [SUM_W-1:0] mean_next;
    assign mean_next = sum_reg[SUM_W-1] ? -div_quot[SUM_W-1:0] : div_quot[SUM_W-1:0];

    // deviation magnitude, clamped to 32 bits
    logic signed [DEV_W-1:0] dev;
    logic [DEV_W-1:0]        dev_abs;
    logic [EXT_W-1:0]        dev_ext;
    logic [MAG_W-1:0]        mag_next;

    always_comb begin
        dev      = DEV_W'(sample_reg) - DEV_W'(mean_reg);
        dev_abs  = dev[DEV_W-1] ? -dev : dev;
        dev_ext  = EXT_W'(dev_abs);
        mag_next = (dev_ext > MAG_LIM) ? {MAG_W{1'b1}} : dev_ext[MAG_W-1:0];
    end

    logic [SQR_W-1:0] sq_next;
    assign sq_next = SQR_W'(mag_reg) * SQR_W'(mag_reg);

    // saturating accumulate
    logic [ACC_W-1:0] acc_wide;
    logic [SQ_W-1:0]  acc_next;

    always_comb begin
        acc_wide = ACC_W'(sqsum_reg) + ACC_W'(sq_reg);
        acc_next = (acc_wide > ACC_W'(SQ_MAX)) ? SQ_MAX : acc_wide[SQ_W-1:0];
    end

    logic [ROOT_W-1:0] root;
    logic              sqrt_done;

    rsd_sqrt #(
        .IN_BITS (SQ_W)
    ) u_sqrt (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (cmd.sqrt_start),
        .radicand (div_quot),
        .root     (root),
        .done     (sqrt_done)
    );

    logic [STD_W-1:0] std_sat;
    logic             few;

    assign std_sat = (|root[ROOT_W-1:STD_W]) ? {STD_W{1'b1}} : root[STD_W-1:0];
    assign few     = count_reg < COUNT_BITS'(2);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg   <= '0;
            sum_reg     <= '0;
            sqsum_reg   <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            if (cmd.accept) begin
                count_reg <= count_next;
                sum_reg   <= sum_next;
                if (s_data.restart) begin
                    sqsum_reg <= '0;
                end
            end else if (cmd.load_acc) begin
                sqsum_reg <= acc_next;
            end
            if (cmd.load_out) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
        if (cmd.accept) begin
            sample_reg <= s_data.sample;
        end
        if (cmd.load_mean) begin
            mean_reg <= mean_next;
        end
        if (cmd.load_mag) begin
            mag_reg <= mag_next;
        end
        if (cmd.load_sq) begin
            sq_reg <= sq_next;
        end
        if (cmd.load_out) begin
            out_reg.std_dev   <= few ? '0 : std_sat;
            out_reg.valid_res <= !few;
        end
    end

    assign sts.div_done    = div_done;
    assign sts.sqrt_done   = sqrt_done;
    assign sts.few_samples = few;
    assign sts.out_busy    = m_valid_reg && !m_ready;

    assign m_valid = m_valid_reg;
    assign m_data  = out_reg;

endmodule

// File: rtl/rsd_control.sv
// ----------------------------------------------------------------------------
// rsd_control
// Sequencer: steps one sample through the datapath.
// ----------------------------------------------------------------------------
module rsd_control (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    output rsd_pkg::rsd_cmd_t cmd,
    input  rsd_pkg::rsd_sts_t sts
);

    rsd_pkg::rsd_state_t state_reg, state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= rsd_pkg::ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        s_ready    = 1'b0;
        case (state_reg)
            rsd_pkg::ST_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    cmd.accept = 1'b1;
                    state_next = rsd_pkg::ST_MEAN_GO;
                end
            end
            rsd_pkg::ST_MEAN_GO: begin
                cmd.div_start = 1'b1;
                state_next    = rsd_pkg::ST_MEAN_WAIT;
            end
            rsd_pkg::ST_MEAN_WAIT: begin
                if (sts.div_done) begin
                    cmd.load_mean = 1'b1;
                    state_next    = rsd_pkg::ST_DEV;
                end
            end
            rsd_pkg::ST_DEV: begin
                cmd.load_mag = 1'b1;
                state_next   = rsd_pkg::ST_SQUARE;
            end
            rsd_pkg::ST_SQUARE: begin
                cmd.load_sq = 1'b1;
                state_next  = rsd_pkg::ST_ACC;
            end
            rsd_pkg::ST_ACC: begin
                cmd.load_acc = 1'b1;
                state_next   = sts.few_samples ? rsd_pkg::ST_OUT : rsd_pkg::ST_VAR_GO;
            end
            rsd_pkg::ST_VAR_GO: begin
                cmd.div_start = 1'b1;
                cmd.div_var   = 1'b1;
                state_next    = rsd_pkg::ST_VAR_WAIT;
            end
            rsd_pkg::ST_VAR_WAIT: begin
                if (sts.div_done) begin
                    state_next = rsd_pkg::ST_ROOT_GO;
                end
            end
            rsd_pkg::ST_ROOT_GO: begin
                cmd.sqrt_start = 1'b1;
                state_next     = rsd_pkg::ST_ROOT_WAIT;
            end
            rsd_pkg::ST_ROOT_WAIT: begin
                if (sts.sqrt_done) begin
                    state_next = rsd_pkg::ST_OUT;
                end
            end
            rsd_pkg::ST_OUT: begin
                if (!sts.out_busy) begin
                    cmd.load_out = 1'b1;
                    state_next   = rsd_pkg::ST_IDLE;
                end
            end
            default: begin
                state_next = rsd_pkg::ST_IDLE;
            end
        endcase
    end

endmodule
